@@ hw/rtl/mpc_pkg.sv @@
// Shared types and constants for the matrix power convergence block.
`timescale 1ns / 1ps
`default_nettype none
package mpc_pkg;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 4;
    localparam int ELEM_W  = 17;
    localparam int DIFF_W  = 24;
    localparam int STEP_W  = 10;
    localparam int SIZE_W  = 5;
    localparam int STAT_W  = 2;
    localparam int CFG_W   = 24;
    localparam int CFGI_W  = 2;

    localparam logic [ELEM_W-1:0] ELEM_MAX = {ELEM_W{1'b1}};
    localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_RUN  = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_NONE  = 2'd0,
        STAT_CONV  = 2'd1,
        STAT_LIMIT = 2'd2
    } run_stat_t;

    typedef enum logic [CFGI_W-1:0] {
        CFG_SIZE  = 2'd0,
        CFG_EPS   = 2'd1,
        CFG_LIMIT = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_STEP,
        ST_ISSUE,
        ST_DRAIN,
        ST_WRITE,
        ST_EVAL
    } eng_state_t;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [ELEM_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [ELEM_W-1:0] element_value;
        logic [STEP_W-1:0] steps;
        logic [STAT_W-1:0] status;
    } rsp_t;

    // status seen by the front end
    typedef struct packed {
        logic              busy;
        logic [STEP_W-1:0] steps;
        run_stat_t         status;
    } eng_stat_t;

endpackage
`default_nettype wire

@@ hw/rtl/matrix_power_convergence_core.sv @@
// Top level: request handshake, configuration registers and result register.
//
//  channel  | ports                       | payload
//  ---------+-----------------------------+-------------------------------------
//  request  | s_valid, s_ready, s_data    | operation, row, col, value
//  result   | m_valid, m_ready, m_data    | element_value, steps, status
//  config   | cfg_we, cfg_index, cfg_data | matrix_size, epsilon, step_limit
//
// Load, read and no-op requests stream back to back while results are taken;
// each result leaves through the pending stage into the result register.
// Reset clears control state only; memory contents stay undefined until written.
// Result stalls back up through the pending stage into s_ready.
`timescale 1ns / 1ps
`default_nettype none
module matrix_power_convergence_core
    import mpc_pkg::*;
#(
    parameter int MAX_SIZE  = 16,
    parameter int FRAC_BITS = 16
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire req_t              s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output rsp_t                   m_data,
    input  wire logic              cfg_we,
    input  wire logic [CFGI_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);
    localparam int AW = $clog2(MAX_SIZE * MAX_SIZE);

    logic [SIZE_W-1:0] size_reg;
    logic [DIFF_W-1:0] eps_reg;
    logic [STEP_W-1:0] limit_reg;
    logic pend_v_reg, pend_v_next, pend_rd_reg, pend_rd_next;
    logic run_wait_reg, run_wait_next;
    logic m_valid_reg, m_valid_next;
    rsp_t m_data_reg, m_data_next;
    logic accept, out_free, in_range;
    logic [AW-1:0] req_addr;
    logic [ELEM_W-1:0] rd_data;
    eng_stat_t stat;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = !run_wait_reg && (!pend_v_reg || out_free);
    assign accept   = s_valid && s_ready;
    assign in_range = (32'(s_data.row) < MAX_SIZE) && (32'(s_data.col) < MAX_SIZE);
    assign req_addr = AW'(s_data.row) * AW'(MAX_SIZE) + AW'(s_data.col);

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg  <= SIZE_W'(16);
            eps_reg   <= DIFF_W'(655);
            limit_reg <= STEP_W'(1000);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SIZE:  size_reg  <= cfg_data[SIZE_W-1:0];
                CFG_EPS:   eps_reg   <= cfg_data[DIFF_W-1:0];
                CFG_LIMIT: limit_reg <= cfg_data[STEP_W-1:0];
                default:   ;
            endcase
        end
    end

    // pending stage and result register
    always_comb begin
        pend_v_next  = pend_v_reg;
        pend_rd_next = pend_rd_reg;
        run_wait_next = run_wait_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;
        if (out_free) begin
            if (pend_v_reg) begin
                m_valid_next               = 1'b1;
                m_data_next.element_value  = pend_rd_reg ? rd_data : '0;
                m_data_next.steps          = stat.steps;
                m_data_next.status         = stat.status;
                pend_v_next                = 1'b0;
            end else if (run_wait_reg && !stat.busy) begin
                m_valid_next               = 1'b1;
                m_data_next.element_value  = '0;
                m_data_next.steps          = stat.steps;
                m_data_next.status         = stat.status;
                run_wait_next              = 1'b0;
            end
        end
        if (accept) begin
            if (s_data.operation == OP_RUN) begin
                run_wait_next = 1'b1;
            end else begin
                pend_v_next  = 1'b1;
                pend_rd_next = (s_data.operation == OP_READ) && in_range;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_v_reg   <= 1'b0;
            run_wait_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            pend_v_reg   <= pend_v_next;
            run_wait_reg <= run_wait_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_rd_reg <= pend_rd_next;
        m_data_reg  <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    mpc_engine #(.MAX_SIZE(MAX_SIZE), .FRAC_BITS(FRAC_BITS)) u_engine (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_size(size_reg),
        .cfg_eps(eps_reg),
        .cfg_limit(limit_reg),
        .start(accept && (s_data.operation == OP_RUN)),
        .ld_we(accept && (s_data.operation == OP_LOAD) && in_range),
        .ld_addr(req_addr),
        .ld_data(s_data.value),
        .rd_en(accept && (s_data.operation == OP_READ) && in_range),
        .rd_addr(req_addr),
        .rd_data(rd_data),
        .stat(stat)
    );

    as_busy_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.busy |-> run_wait_reg)
        else $error("engine running without an outstanding run request");
    as_run_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_data.operation == OP_RUN)) |=> stat.busy)
        else $error("run request did not start the engine");
    as_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pend_v_reg && run_wait_reg && stat.busy))
        else $error("pending request held across a run");
endmodule
`default_nettype wire

@@ hw/rtl/mpc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mpc_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/mpc_engine.sv @@
// Run sequencer: base and ping-pong power memories, multiply and difference datapath.
`timescale 1ns / 1ps
`default_nettype none
module mpc_engine
    import mpc_pkg::*;
#(
    parameter int MAX_SIZE  = 16,
    parameter int FRAC_BITS = 16,
    localparam int AW = $clog2(MAX_SIZE * MAX_SIZE)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [SIZE_W-1:0] cfg_size,
    input  wire logic [DIFF_W-1:0] cfg_eps,
    input  wire logic [STEP_W-1:0] cfg_limit,
    input  wire logic              start,
    input  wire logic              ld_we,
    input  wire logic [AW-1:0]     ld_addr,
    input  wire logic [ELEM_W-1:0] ld_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [ELEM_W-1:0] rd_data,
    output eng_stat_t              stat
);
    localparam int CW = $clog2(MAX_SIZE + 1);
    localparam int PW = 2 * ELEM_W;
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_SIZE - 1);

    eng_state_t state_reg, state_next;
    logic [CW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [STEP_W-1:0] count_reg, count_next, steps_reg, steps_next;
    run_stat_t status_reg, status_next;
    logic cur_sel_reg, cur_sel_next;
    logic v1_reg, v1_next, o1_reg, o1_next, pv_reg;
    logic [PW-1:0] prod_reg;
    logic [ELEM_W-1:0] old_reg, acc_reg, acc_next;
    logic [DIFF_W-1:0] dsum_reg, dsum_next;

    logic [CW-1:0] n, n_m1;
    logic in_act;
    logic [ELEM_W-1:0] base_q, pow0_q, pow1_q, cur_q, adiff;
    logic [PW:0] acc_sum;
    logic [DIFF_W:0] dsum_add;
    logic base_re, cur_re, cur_we, nxt_we;
    logic [AW-1:0] base_ra, cur_ra, wr_addr;
    logic [ELEM_W-1:0] wr_data;

    function automatic logic [AW-1:0] elem_addr(input logic [CW-1:0] r, input logic [CW-1:0] c);
        return AW'(r) * AW'(MAX_SIZE) + AW'(c);
    endfunction

    // clamp size into 1..MAX_SIZE
    always_comb begin
        if (cfg_size == '0) begin
            n = CW'(1);
        end else if (32'(cfg_size) > MAX_SIZE) begin
            n = CW'(MAX_SIZE);
        end else begin
            n = CW'(cfg_size);
        end
        n_m1 = n - CW'(1);
    end

    // copy position lies in the active square
    assign in_act = (i_reg < n) && (j_reg < n);

    assign cur_q   = cur_sel_reg ? pow1_q : pow0_q;
    assign rd_data = cur_q;

    // saturating accumulate of truncated products
    assign acc_sum  = (PW + 1)'(acc_reg) + (PW + 1)'(prod_reg >> FRAC_BITS);
    assign adiff    = (acc_reg >= old_reg) ? acc_reg - old_reg : old_reg - acc_reg;
    assign dsum_add = (DIFF_W + 1)'(dsum_reg) + (DIFF_W + 1)'(adiff);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        k_next       = k_reg;
        count_next   = count_reg;
        steps_next   = steps_reg;
        status_next  = status_reg;
        cur_sel_next = cur_sel_reg;
        v1_next      = 1'b0;
        o1_next      = 1'b0;
        dsum_next    = dsum_reg;
        acc_next     = acc_reg;
        base_re      = 1'b0;
        base_ra      = elem_addr(i_reg, j_reg);
        cur_re       = 1'b0;
        cur_ra       = elem_addr(i_reg, j_reg);
        cur_we       = 1'b0;
        nxt_we       = 1'b0;
        wr_addr      = elem_addr(i_reg, j_reg);
        wr_data      = acc_reg;
        if (pv_reg) begin
            acc_next = (acc_sum > (PW + 1)'(ELEM_MAX)) ? ELEM_MAX : ELEM_W'(acc_sum);
        end
        unique case (state_reg)
            ST_IDLE: begin
                cur_re = rd_en;
                cur_ra = rd_addr;
                if (start) begin
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_COPY_RD;
                end
            end
            // whole array: base into the active square, mirror the rest
            ST_COPY_RD: begin
                if (in_act) begin
                    base_re = 1'b1;
                end else begin
                    cur_re = 1'b1;
                end
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                if (in_act) begin
                    cur_we  = 1'b1;
                    wr_data = base_q;
                end else begin
                    nxt_we  = 1'b1;
                    wr_data = cur_q;
                end
                if (j_reg == LAST_IDX) begin
                    j_next = '0;
                    if (i_reg == LAST_IDX) begin
                        i_next     = '0;
                        count_next = STEP_W'(1);
                        state_next = ST_STEP;
                    end else begin
                        i_next     = i_reg + CW'(1);
                        state_next = ST_COPY_RD;
                    end
                end else begin
                    j_next     = j_reg + CW'(1);
                    state_next = ST_COPY_RD;
                end
            end
            ST_STEP: begin
                i_next    = '0;
                j_next    = '0;
                k_next    = '0;
                dsum_next = '0;
                acc_next  = '0;
                if (count_reg < cfg_limit) begin
                    state_next = ST_ISSUE;
                end else begin
                    steps_next  = '0;
                    status_next = STAT_LIMIT;
                    state_next  = ST_IDLE;
                end
            end
            ST_ISSUE: begin
                cur_re = 1'b1;
                if (k_reg == n) begin
                    o1_next    = 1'b1;
                    state_next = ST_DRAIN;
                end else begin
                    base_re = 1'b1;
                    base_ra = elem_addr(k_reg, j_reg);
                    cur_ra  = elem_addr(i_reg, k_reg);
                    v1_next = 1'b1;
                    k_next  = k_reg + CW'(1);
                end
            end
            ST_DRAIN: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                nxt_we    = 1'b1;
                acc_next  = '0;
                k_next    = '0;
                dsum_next = (dsum_add > (DIFF_W + 1)'(DIFF_MAX)) ? DIFF_MAX
                                                                 : DIFF_W'(dsum_add);
                state_next = ST_ISSUE;
                if (j_reg == n_m1) begin
                    j_next = '0;
                    if (i_reg == n_m1) begin
                        state_next = ST_EVAL;
                    end else begin
                        i_next = i_reg + CW'(1);
                    end
                end else begin
                    j_next = j_reg + CW'(1);
                end
            end
            ST_EVAL: begin
                cur_sel_next = ~cur_sel_reg;
                if (dsum_reg < cfg_eps) begin
                    steps_next  = count_reg;
                    status_next = STAT_CONV;
                    state_next  = ST_IDLE;
                end else begin
                    count_next = count_reg + STEP_W'(1);
                    state_next = ST_STEP;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cur_sel_reg <= 1'b0;
            steps_reg   <= '0;
            status_reg  <= STAT_NONE;
            v1_reg      <= 1'b0;
            o1_reg      <= 1'b0;
            pv_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cur_sel_reg <= cur_sel_next;
            steps_reg   <= steps_next;
            status_reg  <= status_next;
            v1_reg      <= v1_next;
            o1_reg      <= o1_next;
            pv_reg      <= v1_reg;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        i_reg     <= i_next;
        j_reg     <= j_next;
        k_reg     <= k_next;
        count_reg <= count_next;
        dsum_reg  <= dsum_next;
        acc_reg   <= acc_next;
        prod_reg  <= PW'(cur_q) * PW'(base_q);
        if (o1_reg) begin
            old_reg <= cur_q;
        end
    end

    assign stat.busy   = (state_reg != ST_IDLE);
    assign stat.steps  = steps_reg;
    assign stat.status = status_reg;

    mpc_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_SIZE * MAX_SIZE)) u_base (
        .aclk(aclk), .we(ld_we), .waddr(ld_addr), .wdata(ld_data),
        .re(base_re), .raddr(base_ra), .rdata(base_q)
    );

    // copy writes the current buffer and mirrors entries outside the active
    // square into the other one; products write the other one
    mpc_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_SIZE * MAX_SIZE)) u_pow0 (
        .aclk(aclk),
        .we((cur_we && !cur_sel_reg) || (nxt_we && cur_sel_reg)),
        .waddr(wr_addr), .wdata(wr_data),
        .re(cur_re && !cur_sel_reg), .raddr(cur_ra), .rdata(pow0_q)
    );

    mpc_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_SIZE * MAX_SIZE)) u_pow1 (
        .aclk(aclk),
        .we((cur_we && cur_sel_reg) || (nxt_we && !cur_sel_reg)),
        .waddr(wr_addr), .wdata(wr_data),
        .re(cur_re && cur_sel_reg), .raddr(cur_ra), .rdata(pow1_q)
    );

    as_conv_steps: assert property (@(posedge aclk) disable iff (!aresetn)
        (status_reg == STAT_CONV) |-> (steps_reg != '0))
        else $error("converged status with zero step count");
    as_pipe_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        !(v1_reg && o1_reg))
        else $error("product and old-value read issued together");
    as_write_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WRITE) |-> ($past(state_reg) == ST_DRAIN))
        else $error("element written before pipeline drained");
endmodule
`default_nettype wire

@@ verif/mpc_checker.sv @@
// Scoreboard for the matrix power convergence core: predicts and compares results.
`timescale 1ns / 1ps
module mpc_checker
    import mpc_pkg::*;
#(
    parameter int MAX_SIZE  = 16,
    parameter int FRAC_BITS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  req_t              s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  rsp_t              m_data,
    input  logic              cfg_we,
    input  logic [CFGI_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                fail_cnt,
    output int                outstanding
);

    localparam int CELLS = MAX_SIZE * MAX_SIZE;

    // shadow configuration
    logic [SIZE_W-1:0] size_reg;
    logic [DIFF_W-1:0] eps_reg;
    logic [STEP_W-1:0] limit_reg;

    // shadow state
    logic [ELEM_W-1:0] base_m [CELLS];
    logic [ELEM_W-1:0] power_m [CELLS];
    logic [ELEM_W-1:0] prod_m [CELLS];
    logic [STEP_W-1:0] conv_steps;
    run_stat_t         conv_status;

    rsp_t expected_rsp [$];

    assign outstanding = expected_rsp.size();

    // full run: copy base into power, then multiply until converged or out of steps
    task automatic power_iterate();
        int          n;
        int          idx;
        logic [63:0] acc;
        logic [63:0] dsum;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        n = (size_reg == 0) ? 1 : ((size_reg > MAX_SIZE) ? MAX_SIZE : int'(size_reg));
        for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++)
                power_m[i*MAX_SIZE+j] = base_m[i*MAX_SIZE+j];
        for (int cnt = 1; cnt < int'(limit_reg); cnt++) begin
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++) begin
                    acc = 0;
                    for (int k = 0; k < n; k++)
                        acc += (64'(power_m[i*MAX_SIZE+k]) * 64'(base_m[k*MAX_SIZE+j]))
                               >> FRAC_BITS;
                    prod_m[i*MAX_SIZE+j] = (acc > 64'(ELEM_MAX)) ? ELEM_MAX : acc[ELEM_W-1:0];
                end
            dsum = 0;
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++) begin
                    idx = i*MAX_SIZE+j;
                    a = prod_m[idx];
                    b = power_m[idx];
                    dsum += (a >= b) ? 64'(a - b) : 64'(b - a);
                    if (dsum > 64'(DIFF_MAX)) dsum = 64'(DIFF_MAX);
                end
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    power_m[i*MAX_SIZE+j] = prod_m[i*MAX_SIZE+j];
            if (dsum < 64'(eps_reg)) begin
                conv_steps  = STEP_W'(cnt);
                conv_status = STAT_CONV;
                return;
            end
        end
        conv_steps  = '0;
        conv_status = STAT_LIMIT;
    endtask

    // one request in, one expected result out
    task automatic apply_request(input req_t r);
        rsp_t rsp;
        int   elem_idx;
        bit   in_range;
        elem_idx = int'(r.row) * MAX_SIZE + int'(r.col);
        in_range = (int'(r.row) < MAX_SIZE) && (int'(r.col) < MAX_SIZE);
        rsp.element_value = '0;
        case (op_t'(r.operation))
            OP_LOAD: if (in_range) base_m[elem_idx] = r.value;
            OP_RUN:  power_iterate();
            OP_READ: if (in_range) rsp.element_value = power_m[elem_idx];
            default: ;
        endcase
        rsp.steps  = conv_steps;
        rsp.status = conv_status;
        expected_rsp.push_back(rsp);
    endtask

    always @(posedge aclk) begin
        rsp_t exp_rsp;
        if (!aresetn) begin
            size_reg    <= 5'd16;
            eps_reg     <= 24'd655;
            limit_reg   <= 10'd1000;
            conv_steps  = '0;
            conv_status = STAT_NONE;
            fail_cnt    <= 0;
            expected_rsp.delete();
        end else begin
            // config writes only happen while idle
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_SIZE:  size_reg  <= cfg_data[SIZE_W-1:0];
                    CFG_EPS:   eps_reg   <= cfg_data[DIFF_W-1:0];
                    CFG_LIMIT: limit_reg <= cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) apply_request(s_data);
            if (m_valid && m_ready) begin
                if (expected_rsp.size() == 0) begin
                    $display("%0t: unexpected result %p", $time, m_data);
                    fail_cnt <= fail_cnt + 1;
                end else begin
                    exp_rsp = expected_rsp.pop_front();
                    if (m_data.element_value !== exp_rsp.element_value ||
                        m_data.steps !== exp_rsp.steps || m_data.status !== exp_rsp.status) begin
                        $display("%0t: mismatch expected elem=%0d steps=%0d status=%0d, actual elem=%0d steps=%0d status=%0d",
                                 $time, exp_rsp.element_value, exp_rsp.steps, exp_rsp.status,
                                 m_data.element_value, m_data.steps, m_data.status);
                        fail_cnt <= fail_cnt + 1;
                    end
                end
            end
        end
    end

endmodule

@@ verif/tb_top.sv @@
// Stimulus and verdict for the matrix power convergence core.
`timescale 1ns / 1ps
module tb_top;
    import mpc_pkg::*;

    localparam int MAX_SIZE = 16;
    localparam int CELLS    = MAX_SIZE * MAX_SIZE;
    localparam int WDOG_MAX = 300000;

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    req_t              s_data;
    logic              m_valid;
    logic              m_ready;
    rsp_t              m_data;
    logic              cfg_we;
    logic [CFGI_W-1:0] cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    int                fail_cnt;
    int                outstanding;

    int sent_cnt;
    int rcv_cnt;
    int burst_left;
    int idle_cycles;
    int cur_size;
    bit base_loaded [CELLS];
    bit power_known [CELLS];

    matrix_power_convergence_core i_dut (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data, .cfg_we, .cfg_index, .cfg_data
    );

    mpc_checker i_checker (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .m_valid, .m_ready, .m_data, .cfg_we, .cfg_index, .cfg_data,
        .fail_cnt, .outstanding
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // receiver: alternating stretches of always-ready, random and heavy stalls
    int rdy_mode;
    int rdy_left;
    always @(negedge aclk) begin
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(0, 2);
            rdy_left = $urandom_range(5, 60);
        end else begin
            rdy_left = rdy_left - 1;
        end
        case (rdy_mode)
            0:       m_ready <= 1'b1;
            1:       m_ready <= $urandom_range(0, 1);
            default: m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // response count and stall watchdog
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) rcv_cnt <= rcv_cnt + 1;
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WDOG_MAX) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // called at a falling edge; returns at a falling edge with valid possibly still high
    task automatic push_request(input op_t op, input int row, input int col,
                                input logic [ELEM_W-1:0] val);
        req_t r;
        int   n;
        r.operation = op;
        r.row       = IDX_W'(row);
        r.col       = IDX_W'(col);
        r.value     = val;
        s_data  <= r;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_cnt = sent_cnt + 1;
        if (op == OP_LOAD) base_loaded[row*MAX_SIZE+col] = 1'b1;
        if (op == OP_RUN) begin
            n = cur_size;
            for (int i = 0; i < n; i++)
                for (int j = 0; j < n; j++)
                    power_known[i*MAX_SIZE+j] = 1'b1;
        end
        @(negedge aclk);
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 2) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end else begin
            burst_left = burst_left - 1;
        end
    endtask

    // drop valid and wait until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        while (rcv_cnt != sent_cnt) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // holds the write enable high; the caller drops it after the last write
    task automatic write_reg(input cfg_idx_t idx, input int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        @(negedge aclk);
    endtask

    task automatic set_config(input int size, input int eps, input int limit);
        drain();
        write_reg(CFG_SIZE, size);
        write_reg(CFG_EPS, eps);
        write_reg(CFG_LIMIT, limit);
        cfg_we   <= 1'b0;
        cur_size = (size == 0) ? 1 : ((size > MAX_SIZE) ? MAX_SIZE : size);
    endtask

    // mostly near-stochastic entries, plus extremes and raw random bits
    function automatic logic [ELEM_W-1:0] pick_value();
        int sel;
        int center;
        sel    = $urandom_range(0, 9);
        center = 65536 / cur_size;
        if (sel == 0) return '0;
        if (sel == 1) return ELEM_MAX;
        if (sel == 2) return ELEM_W'($urandom);
        return ELEM_W'(center - (center / 4) + $urandom_range(0, center / 2));
    endfunction

    function automatic bit all_loaded();
        for (int i = 0; i < cur_size; i++)
            for (int j = 0; j < cur_size; j++)
                if (!base_loaded[i*MAX_SIZE+j]) return 1'b0;
        return 1'b1;
    endfunction

    task automatic load_missing();
        for (int i = 0; i < cur_size; i++)
            for (int j = 0; j < cur_size; j++)
                if (!base_loaded[i*MAX_SIZE+j]) push_request(OP_LOAD, i, j, pick_value());
    endtask

    // random mix of loads, reads, runs and no-ops; runs are capped since they are slow
    task automatic random_phase(input int count, input int max_runs);
        int runs;
        int sel;
        int r;
        int c;
        bit found;
        runs = 0;
        for (int k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            if (sel < 15 && runs < max_runs) begin
                if (!all_loaded()) load_missing();
                push_request(OP_RUN, 0, 0, ELEM_W'($urandom));
                runs = runs + 1;
            end else if (sel < 55) begin
                found = 1'b0;
                for (int t = 0; t < 30 && !found; t++) begin
                    r = $urandom_range(0, MAX_SIZE - 1);
                    c = $urandom_range(0, MAX_SIZE - 1);
                    found = power_known[r*MAX_SIZE+c];
                end
                if (found) push_request(OP_READ, r, c, ELEM_W'($urandom));
                else push_request(OP_NOP, r, c, ELEM_W'($urandom));
            end else if (sel < 92) begin
                if ($urandom_range(0, 4) == 0) begin
                    r = $urandom_range(0, MAX_SIZE - 1);
                    c = $urandom_range(0, MAX_SIZE - 1);
                end else begin
                    r = $urandom_range(0, cur_size - 1);
                    c = $urandom_range(0, cur_size - 1);
                end
                push_request(OP_LOAD, r, c, pick_value());
            end else begin
                push_request(OP_NOP, $urandom_range(0, 15), $urandom_range(0, 15),
                             ELEM_W'($urandom));
            end
        end
        if (runs == 0) begin
            if (!all_loaded()) load_missing();
            push_request(OP_RUN, 0, 0, '0);
        end
    endtask

    initial begin
        int sz;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        m_ready    = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        sent_cnt   = 0;
        rcv_cnt    = 0;
        burst_left = 4;
        cur_size   = MAX_SIZE;
        rdy_left   = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: status before any run, extremes, outside loads, no-op
        set_config(2, 24'hFFFFFF, 1023);
        push_request(OP_NOP, 15, 15, ELEM_MAX);
        push_request(OP_LOAD, 0, 0, '0);
        push_request(OP_LOAD, 0, 1, ELEM_MAX);
        push_request(OP_LOAD, 1, 0, 17'h08000);
        push_request(OP_LOAD, 1, 1, 17'h08000);
        push_request(OP_LOAD, 15, 15, 17'h15555);
        push_request(OP_RUN, 0, 0, '0);
        push_request(OP_READ, 0, 0, '0);
        push_request(OP_READ, 0, 1, '0);
        push_request(OP_READ, 1, 0, '0);
        push_request(OP_READ, 1, 1, '0);
        push_request(OP_NOP, 1, 1, '0);
        // zero epsilon never converges: runs to the step limit
        set_config(2, 0, 1023);
        push_request(OP_RUN, 0, 0, '0);
        push_request(OP_READ, 1, 1, '0);
        // size zero acts as one
        set_config(0, 655, 50);
        push_request(OP_LOAD, 0, 0, 17'h10000);
        push_request(OP_RUN, 0, 0, '0);
        push_request(OP_READ, 0, 0, '0);
        // step limit of one and zero: no products formed
        set_config(1, 655, 1);
        push_request(OP_RUN, 0, 0, '0);
        set_config(1, 655, 0);
        push_request(OP_RUN, 0, 0, '0);
        push_request(OP_READ, 0, 0, '0);

        // random phases across sizes, thresholds and limits
        set_config(1, 0, 1023);
        random_phase(15, 2);
        set_config(3, 655, 200);
        random_phase(25, 3);
        set_config(4, 1000, 100);
        random_phase(25, 3);
        set_config(5, $urandom_range(0, 24'hFFFFFF), 20);
        random_phase(20, 2);
        set_config(8, $urandom_range(500, 5000), 10);
        random_phase(25, 2);
        // oversize acts as the full matrix; fill everything first
        set_config(31, 655, 1);
        load_missing();
        push_request(OP_RUN, 0, 0, '0);
        set_config(16, 300, 3);
        random_phase(25, 2);
        set_config(16, 24'hFFFFFF, 0);
        random_phase(15, 2);
        set_config(6, $urandom_range(0, 3000), 30);
        random_phase(25, 2);
        set_config(2, $urandom_range(0, 24'hFFFFFF), 1023);
        random_phase(25, 3);
        set_config(7, 24'hFFFFFF, 2);
        random_phase(20, 2);

        drain();
        repeat (20) @(posedge aclk);
        if (fail_cnt == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
